// File: sv/qpa_pkg.sv
// Package for the QoS profile index allocator.
// Holds table sizes, request/response codes and the channel payload structs.
// No dependencies.
package qpa_pkg;

    // Table geometry.
    localparam int TABLE_SIZE  = 128;
    localparam int FIRST_ID    = 8;
    localparam int STACK_DEPTH = TABLE_SIZE - FIRST_ID;
    localparam int IDX_W       = 7;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int NEED_W      = 8;

    // Request action codes.
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_DEL   = 3'd1;
    localparam logic [2:0] ACT_SET   = 3'd2;
    localparam logic [2:0] ACT_CHECK = 3'd3;

    // Response status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BUSY       = 3'd1;
    localparam logic [2:0] ST_NOT_EXIST  = 3'd2;
    localparam logic [2:0] ST_BAD_ACTION = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd4;

    // Request payload.
    typedef struct packed {
        logic [2:0]        action;
        logic [IDX_W-1:0]  profile_index;
        logic [NEED_W-1:0] needed_count;
        logic [2:0]        traffic_class;
        logic [5:0]        dscp_value;
        logic [2:0]        user_priority;
        logic [2:0]        exp_value;
    } t_qpa_req;

    // Response payload.
    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] assigned_index;
        logic             entry_write;
        logic [IDX_W-1:0] entry_index;
        logic [2:0]       entry_traffic_class;
        logic [5:0]       entry_dscp;
        logic [2:0]       entry_priority;
        logic [2:0]       entry_exp;
    } t_qpa_rsp;

endpackage

// File: sv/qpa_out_stage.sv
// Response output register for the QoS profile index allocator.
// Holds one finished response until the consumer takes it; uses qpa_pkg.
module qpa_out_stage
    import qpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_qpa_rsp i_data,
    output logic     o_can_load,
    output logic     o_valid,
    input  logic     i_ready,
    output t_qpa_rsp o_data
);

    logic     r_valid;
    t_qpa_rsp r_data;

    // A new response may enter when the register is empty or being drained.
    assign o_can_load = !r_valid || i_ready;

    // Valid flag under reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/qos_profile_id_allocator_core.sv
// A request accepted in idle has its stack and flag memories read into registers;
// the execute state then loads its response into the output register once it can.
// No new request is taken before the previous request has done its write-back.
// Reset: synchronous; afterwards a clearing pass over all 128 entries preloads the
// free stack and clears the allocated flags, with no request accepted until it ends.
module qos_profile_id_allocator_core
    import qpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_qpa_req i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_qpa_rsp o_out_data
);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_init_cnt;
    logic [SP_W-1:0]  r_sp, n_sp;
    t_qpa_req         r_req;

    // Memories and their registered read data.
    logic [IDX_W-1:0] r_stack_mem [STACK_DEPTH];
    logic             r_flag_mem  [TABLE_SIZE];
    logic [IDX_W-1:0] r_stack_rd;
    logic             r_flag_rd;

    logic             w_accept;
    logic             w_commit;
    logic             w_can_load;
    t_qpa_rsp         w_rsp;
    logic             w_stack_we, w_flag_we;
    logic [IDX_W-1:0] w_stack_waddr, w_stack_wdata, w_flag_waddr;
    logic             w_flag_wdata;
    logic             x_stack_we, x_flag_we, x_flag_wdata;
    logic [IDX_W-1:0] x_flag_waddr;
    logic [SP_W-1:0]  w_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_EXEC) && w_can_load;
    assign w_free     = SP_W'(STACK_DEPTH) - r_sp;

    // Execute stage: decide the response and the write-back from the read data.
    always_comb begin
        w_rsp        = '0;
        n_sp         = r_sp;
        x_stack_we   = 1'b0;
        x_flag_we    = 1'b0;
        x_flag_wdata = 1'b0;
        x_flag_waddr = r_req.profile_index;
        case (r_req.action)
            ACT_ADD: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    w_rsp.status = ST_BUSY;
                end else begin
                    w_rsp.status              = ST_OK;
                    w_rsp.assigned_index      = r_stack_rd;
                    w_rsp.entry_write         = 1'b1;
                    w_rsp.entry_index         = r_stack_rd;
                    w_rsp.entry_traffic_class = r_req.traffic_class;
                    w_rsp.entry_dscp          = r_req.dscp_value;
                    w_rsp.entry_priority      = r_req.user_priority;
                    w_rsp.entry_exp           = r_req.exp_value;
                    n_sp                      = r_sp + 1'b1;
                    x_flag_we                 = 1'b1;
                    x_flag_wdata              = 1'b1;
                    x_flag_waddr              = r_stack_rd;
                end
            end
            ACT_DEL: begin
                if (!r_flag_rd) begin
                    w_rsp.status = ST_NOT_EXIST;
                end else begin
                    x_flag_we = 1'b1;
                    if (r_sp == '0) begin
                        w_rsp.status = ST_UNDERFLOW;
                    end else begin
                        w_rsp.status = ST_OK;
                        n_sp         = r_sp - 1'b1;
                        x_stack_we   = 1'b1;
                    end
                end
            end
            ACT_SET: begin
                if (!r_flag_rd) begin
                    w_rsp.status = ST_NOT_EXIST;
                end else begin
                    w_rsp.status              = ST_OK;
                    w_rsp.entry_write         = 1'b1;
                    w_rsp.entry_index         = r_req.profile_index;
                    w_rsp.entry_traffic_class = r_req.traffic_class;
                    w_rsp.entry_dscp          = r_req.dscp_value;
                    w_rsp.entry_priority      = r_req.user_priority;
                    w_rsp.entry_exp           = r_req.exp_value;
                end
            end
            ACT_CHECK: begin
                if ({1'b0, NEED_W'(w_free)} >= {1'b0, r_req.needed_count}) begin
                    w_rsp.status = ST_OK;
                end else begin
                    w_rsp.status = ST_BUSY;
                end
            end
            default: begin
                w_rsp.status = ST_BAD_ACTION;
            end
        endcase
    end

    // Memory write ports: the clearing pass or the execute write-back.
    always_comb begin
        if (r_state == S_INIT) begin
            w_stack_we    = ({1'b0, r_init_cnt} < (IDX_W + 1)'(STACK_DEPTH));
            w_stack_waddr = r_init_cnt;
            w_stack_wdata = IDX_W'(FIRST_ID) + r_init_cnt;
            w_flag_we     = 1'b1;
            w_flag_waddr  = r_init_cnt;
            w_flag_wdata  = 1'b0;
        end else begin
            w_stack_we    = w_commit && x_stack_we;
            w_stack_waddr = IDX_W'(n_sp);
            w_stack_wdata = r_req.profile_index;
            w_flag_we     = w_commit && x_flag_we;
            w_flag_waddr  = x_flag_waddr;
            w_flag_wdata  = x_flag_wdata;
        end
    end

    // Free stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_stack_we) begin
            r_stack_mem[w_stack_waddr] <= w_stack_wdata;
        end
        if (w_accept && (r_sp < SP_W'(STACK_DEPTH))) begin
            r_stack_rd <= r_stack_mem[IDX_W'(r_sp)];
        end
    end

    // Allocated flag memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_flag_we) begin
            r_flag_mem[w_flag_waddr] <= w_flag_wdata;
        end
        if (w_accept) begin
            r_flag_rd <= r_flag_mem[i_in_data.profile_index];
        end
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init_cnt == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_cnt <= '0;
            r_sp       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_init_cnt <= r_init_cnt + 1'b1;
            end
            if (w_commit) begin
                r_sp <= n_sp;
            end
        end
    end

    // Response register toward the consumer.
    qpa_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_commit),
        .i_data     (w_rsp),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

// File: sv/qpa_checker.sv
// Port-level checks for the QoS profile index allocator.
// Depends on qpa_pkg; bound to qos_profile_id_allocator_core below.
module qpa_checker
    import qpa_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_qpa_req i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_qpa_rsp o_out_data
);

    // A stalled response stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled response changed");

    // Reset empties the response register and drops the input ready.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("response or ready after reset");

    // One request at a time: no request is taken right after another.
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted back to back");

    // A failed request hands out nothing and writes no entry.
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK)
            |-> !o_out_data.entry_write && (o_out_data.assigned_index == '0))
        else $error("failed request carries an entry write");

    // A request accepted while no response waits yields its response via the execute state.
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##1 o_out_valid)
        else $error("response missing after request");

endmodule

bind qos_profile_id_allocator_core qpa_checker u_qpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: bench/tb_qos_profile_id_allocator_core.sv
// Self-checking testbench for qos_profile_id_allocator_core.
// Depends on qpa_pkg for the request/response structs and codes; a scoreboard
// class predicts every response from its own copy of the free stack and flags.
`timescale 1ns / 100ps

module tb_qos_profile_id_allocator_core
    import qpa_pkg::*;
();

    // Action codes above check are all invalid.
    localparam logic [2:0] ACT_INVALID_LO = 3'd4;
    localparam logic [2:0] ACT_INVALID_HI = 3'd7;
    localparam int         MAX_NEED       = TABLE_SIZE;
    localparam int         RANDOM_ITEMS   = 1430;
    localparam int         DRAIN_CYCLES   = 20;

    typedef enum {PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} t_traffic_phase;

    // Scoreboard: tracks the allocator state and the responses still owed.
    class t_qos_alloc_scoreboard;
        logic [IDX_W-1:0] free_ids [STACK_DEPTH];
        int unsigned      stack_ptr;
        bit               alloc_flag [TABLE_SIZE];
        t_qpa_rsp         pending_responses [$];
        int               errors;

        function new();
            for (int i = 0; i < STACK_DEPTH; i++) free_ids[i] = IDX_W'(FIRST_ID + i);
            for (int i = 0; i < TABLE_SIZE; i++) alloc_flag[i] = 1'b0;
            stack_ptr = 0;
            errors    = 0;
        endfunction

        // Copies the entry contents of a request into a response.
        function void fill_entry(inout t_qpa_rsp rsp, input logic [IDX_W-1:0] idx,
                                 input t_qpa_req req);
            rsp.entry_write         = 1'b1;
            rsp.entry_index         = idx;
            rsp.entry_traffic_class = req.traffic_class;
            rsp.entry_dscp          = req.dscp_value;
            rsp.entry_priority      = req.user_priority;
            rsp.entry_exp           = req.exp_value;
        endfunction

        // Applies an accepted request to the state and queues its response.
        function void note_request(t_qpa_req req);
            t_qpa_rsp         rsp;
            logic [IDX_W-1:0] idx;
            rsp = '0;
            idx = req.profile_index;
            case (req.action)
                ACT_ADD: begin
                    if (stack_ptr >= STACK_DEPTH) begin
                        rsp.status = ST_BUSY;
                    end else begin
                        idx = free_ids[stack_ptr];
                        stack_ptr++;
                        alloc_flag[idx]    = 1'b1;
                        rsp.status         = ST_OK;
                        rsp.assigned_index = idx;
                        fill_entry(rsp, idx, req);
                    end
                end
                ACT_DEL: begin
                    if (!alloc_flag[idx]) begin
                        rsp.status = ST_NOT_EXIST;
                    end else begin
                        alloc_flag[idx] = 1'b0;
                        // A full stack drops the index; legal traffic never gets here.
                        if (stack_ptr == 0) begin
                            rsp.status = ST_UNDERFLOW;
                        end else begin
                            stack_ptr--;
                            free_ids[stack_ptr] = idx;
                            rsp.status = ST_OK;
                        end
                    end
                end
                ACT_SET: begin
                    if (!alloc_flag[idx]) begin
                        rsp.status = ST_NOT_EXIST;
                    end else begin
                        rsp.status = ST_OK;
                        fill_entry(rsp, idx, req);
                    end
                end
                ACT_CHECK: begin
                    rsp.status = (int'(STACK_DEPTH - stack_ptr) >= int'(req.needed_count))
                                 ? ST_OK : ST_BUSY;
                end
                default: begin
                    rsp.status = ST_BAD_ACTION;
                end
            endcase
            pending_responses.push_back(rsp);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // Compares an accepted response with the oldest one owed.
        function void check_response(t_qpa_rsp got);
            t_qpa_rsp want;
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %h", $time, got);
                return;
            end
            want = pending_responses.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("assigned_index", 8'(want.assigned_index), 8'(got.assigned_index));
            compare_field("entry_write", 8'(want.entry_write), 8'(got.entry_write));
            compare_field("entry_index", 8'(want.entry_index), 8'(got.entry_index));
            compare_field("entry_traffic_class", 8'(want.entry_traffic_class),
                          8'(got.entry_traffic_class));
            compare_field("entry_dscp", 8'(want.entry_dscp), 8'(got.entry_dscp));
            compare_field("entry_priority", 8'(want.entry_priority), 8'(got.entry_priority));
            compare_field("entry_exp", 8'(want.entry_exp), 8'(got.entry_exp));
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_qpa_req i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_qpa_rsp o_out_data;

    t_qos_alloc_scoreboard sb;
    int idle_free_left  = 0;
    int ready_hold      = 0;
    int ready_roll      = 0;
    int sent            = 0;

    qos_profile_id_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Response side: random stalls, mostly short, some long, with stall-free runs.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 8) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(30, 80);
            end else if (ready_roll < 60) begin
                i_out_ready <= 1'b1;
                ready_hold  <= 0;
            end else if (ready_roll < 93) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(10, 40);
            end
        end
    end

    // Every response taken by the bench is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_response(o_out_data);
    end

    // Idle cycles before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (idle_free_left > 0) begin
            idle_free_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            idle_free_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic t_qpa_req make_req(logic [2:0] action, int idx, int need,
                                          int tc, int dscp, int prio, int exp_v);
        t_qpa_req req;
        req.action        = action;
        req.profile_index = IDX_W'(idx);
        req.needed_count  = NEED_W'(need);
        req.traffic_class = 3'(tc);
        req.dscp_value    = 6'(dscp);
        req.user_priority = 3'(prio);
        req.exp_value     = 3'(exp_v);
        return req;
    endfunction

    // Finds an allocated index starting from a random point, or any index if none.
    function automatic int pick_allocated();
        int start;
        int idx;
        start = $urandom_range(0, TABLE_SIZE - 1);
        for (int k = 0; k < TABLE_SIZE; k++) begin
            idx = (start + k) % TABLE_SIZE;
            if (sb.alloc_flag[idx]) return idx;
        end
        return start;
    endfunction

    // Builds one random request, weighted by the traffic phase.
    function automatic t_qpa_req random_request(t_traffic_phase phase);
        t_qpa_req   req;
        logic [2:0] action;
        int         roll;
        int         free_cnt;
        int         need;
        int         idx;
        int         w_add, w_del, w_set, w_chk;
        case (phase)
            PH_FILL:  begin w_add = 85; w_del = 89; w_set = 95; w_chk = 98; end
            PH_MIX:   begin w_add = 35; w_del = 65; w_set = 85; w_chk = 95; end
            PH_DRAIN: begin w_add = 5;  w_del = 80; w_set = 90; w_chk = 98; end
            default:  begin w_add = 20; w_del = 40; w_set = 60; w_chk = 75; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_add)      action = ACT_ADD;
        else if (roll < w_del) action = ACT_DEL;
        else if (roll < w_set) action = ACT_SET;
        else if (roll < w_chk) action = ACT_CHECK;
        else                   action = 3'($urandom_range(ACT_INVALID_LO, ACT_INVALID_HI));

        if (phase != PH_NOISE && $urandom_range(0, 99) < 75) idx = pick_allocated();
        else idx = $urandom_range(0, TABLE_SIZE - 1);

        // Checks often ask for about the number of free indices.
        free_cnt = STACK_DEPTH - int'(sb.stack_ptr);
        if (phase != PH_NOISE && $urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 2))
                0:       need = free_cnt;
                1:       need = free_cnt + 1;
                default: need = (free_cnt > 0) ? free_cnt - 1 : 0;
            endcase
        end else begin
            need = $urandom_range(0, MAX_NEED);
        end

        req = make_req(action, idx, need, $urandom_range(0, 7), $urandom_range(0, 63),
                       $urandom_range(0, 7), $urandom_range(0, 7));
        return req;
    endfunction

    // Presents one request and waits for it to be taken.
    task automatic send_request(input t_qpa_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req);
        sent++;
    endtask

    // Run time limit.
    initial begin
        #4000000;
        $display("qos_profile_id_allocator_core regression: fail");
        $finish;
    end

    initial begin
        t_traffic_phase phase;
        int             phase_len;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: check limits, field extremes, every action and every error but underflow.
        send_request(make_req(ACT_CHECK, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_CHECK, 127, STACK_DEPTH, 7, 63, 7, 7));
        send_request(make_req(ACT_CHECK, 0, STACK_DEPTH + 1, 0, 0, 0, 0));
        send_request(make_req(ACT_CHECK, 0, MAX_NEED, 0, 0, 0, 0));
        send_request(make_req(ACT_ADD, 127, 255, 7, 63, 7, 7));
        send_request(make_req(ACT_ADD, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_SET, FIRST_ID, 0, 5, 42, 2, 3));
        send_request(make_req(ACT_SET, TABLE_SIZE - 1, 0, 1, 1, 1, 1));
        send_request(make_req(ACT_SET, 0, 0, 6, 21, 4, 6));
        send_request(make_req(ACT_DEL, FIRST_ID - 1, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_DEL, FIRST_ID + 1, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_DEL, FIRST_ID + 1, 0, 0, 0, 0, 0));
        for (int a = ACT_INVALID_LO; a <= ACT_INVALID_HI; a++)
            send_request(make_req(3'(a), 127, MAX_NEED, 7, 63, 7, 7));
        send_request(make_req(ACT_ADD, 85, 0, 2, 17, 5, 1));
        send_request(make_req(ACT_CHECK, 0, STACK_DEPTH - 1, 0, 0, 0, 0));
        send_request(make_req(ACT_CHECK, 0, STACK_DEPTH - 2, 0, 0, 0, 0));
        send_request(make_req(ACT_SET, FIRST_ID + 1, 0, 3, 12, 6, 5));

        // Random traffic in rounds: fill toward an empty stack, mixed, drain, then noise.
        sent  = 0;
        phase = PH_FILL;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                PH_FILL:  phase_len = $urandom_range(160, 200);
                PH_MIX:   phase_len = $urandom_range(80, 140);
                PH_DRAIN: phase_len = $urandom_range(140, 190);
                default:  phase_len = $urandom_range(20, 40);
            endcase
            repeat (phase_len)
                if (sent < RANDOM_ITEMS) send_request(random_request(phase));
            case (phase)
                PH_FILL:  phase = PH_MIX;
                PH_MIX:   phase = PH_DRAIN;
                PH_DRAIN: phase = PH_NOISE;
                default:  phase = PH_FILL;
            endcase
        end
        i_in_valid <= 1'b0;

        while (sb.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_responses.size() == 0)
            $display("qos_profile_id_allocator_core regression: pass");
        else
            $display("qos_profile_id_allocator_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
sv/qpa_pkg.sv
sv/qpa_out_stage.sv
sv/qos_profile_id_allocator_core.sv
sv/qpa_checker.sv
bench/tb_qos_profile_id_allocator_core.sv
